// File: rtl/core/plcc_pkg.sv
// Shared constants, types and state codes of the line crossing counter.
`default_nettype none
package plcc_pkg;

   localparam int MAX_SEGMENTS = 16;
   localparam int ADDR_W       = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;

   localparam int SEG_IDX_W  = 4;
   localparam int COEF_W     = 32;
   localparam int COORD_W    = 16;
   localparam int SEG_CNT_W  = 5;
   localparam int SCALE_W    = 24;
   localparam int HYST_W     = 20;
   localparam int COUNT_W    = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;
   localparam int REQ_DATA_W = 136;
   localparam int RSP_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] CSR_SEGMENT_COUNT = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_INDEX_SCALE   = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_HYST_MARGIN   = 2'd2;

   localparam logic OP_LOAD  = 1'b0;
   localparam logic OP_COUNT = 1'b1;

   typedef struct packed {
      logic [COEF_W-1:0] slope;
      logic [COEF_W-1:0] intercept;
   } seg_entry_type;

   typedef struct packed {
      logic index_en;
      logic line_en;
   } eval_ctl_type;

   typedef struct packed {
      logic secondary;
      logic primary;
   } side_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INDEX,
      ST_READ,
      ST_MUL,
      ST_CMP,
      ST_RESULT
   } state_type;

endpackage
`default_nettype wire

// File: rtl/core/piecewise_line_crossing_counter_core.sv
// Top level of the piecewise line crossing counter with hysteresis.
// Usage:
//   req_ channel carries one item per handshake; req_tuser is the operation
//   (0 load segment, 1 evaluate a track step). A load writes slope and
//   intercept of segment seg_index into the coefficient memory. A track step
//   classifies its start and end point against the covering segment.
//   rsp_ channel returns exactly one result item per request item: both
//   totals after the item and the two counted flags.
//   csr_ port writes segment_count, index_scale and the hysteresis margin;
//   write only while no item is in flight.
// Sequencing:
//   A load goes through the result step into the output register. A track
//   step passes each point through index multiply, memory read, line multiply
//   and compare on the one shared point unit, points handled one after the other.
//   A new item is accepted only in the idle step, after the last result has gone
//   into the output register. A stalled receiver holds one finished result in
//   the output register while the next item is worked on; the block then
//   waits in the result step until it drains.
// Reset clears both totals and the registers to segment_count 1, index_scale
// 0 and hysteresis margin 0. The coefficient memory is not cleared.
`default_nettype none
module piecewise_line_crossing_counter_core
   import plcc_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // seg_index, slope, intercept, start_x, start_y, end_x, end_y, zero fill
   input  wire logic [REQ_DATA_W-1:0]  req_tdata,
   // operation
   input  wire logic                   req_tuser,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // primary_count, secondary_count, counted_primary, counted_secondary, zero fill
   output      logic [RSP_DATA_W-1:0]  rsp_tdata,
   input  wire logic                   csr_we,
   input  wire logic [CSR_IDX_W-1:0]   csr_index,
   input  wire logic [CSR_DATA_W-1:0]  csr_wdata
);

   state_type state_ff, state_in;

   logic [SEG_CNT_W-1:0]     seg_count_ff;
   logic [SCALE_W-1:0]       scale_ff;
   logic [HYST_W-1:0]        hyst_ff;

   logic                     op_ff;
   logic [COORD_W-1:0]       sx_ff, sy_ff, ex_ff, ey_ff;
   logic                     pt_sel_ff, pt_sel_in;
   side_type                 side0_ff, side1_ff;

   logic [COUNT_W-1:0]       prim_ff, sec_ff;
   logic                     rsp_valid_ff;
   logic [COUNT_W-1:0]       rsp_prim_ff, rsp_sec_ff;
   logic                     rsp_cp_ff, rsp_cs_ff;

   logic                     accept;
   logic                     res_load;
   logic                     cp, cs;
   eval_ctl_type             ctl;
   seg_entry_type            wr_entry;
   seg_entry_type            rd_entry;
   logic [ADDR_W-1:0]        rd_addr;
   logic                     rd_en;
   side_type                 side;
   logic signed [COORD_W-1:0] cur_x, cur_y;

   assign accept = req_tvalid && req_tready;

   assign wr_entry.slope     = req_tdata[35:4];
   assign wr_entry.intercept = req_tdata[67:36];

   always_ff @(posedge clock) begin
      if (reset) begin
         seg_count_ff <= SEG_CNT_W'(1);
         scale_ff     <= '0;
         hyst_ff      <= '0;
      end else if (csr_we) begin
         case (csr_index)
            CSR_SEGMENT_COUNT: seg_count_ff <= csr_wdata[SEG_CNT_W-1:0];
            CSR_INDEX_SCALE:   scale_ff     <= csr_wdata[SCALE_W-1:0];
            CSR_HYST_MARGIN:   hyst_ff      <= csr_wdata[HYST_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         op_ff <= req_tuser;
         sx_ff <= req_tdata[83:68];
         sy_ff <= req_tdata[99:84];
         ex_ff <= req_tdata[115:100];
         ey_ff <= req_tdata[131:116];
      end
      if (state_ff == ST_CMP) begin
         if (pt_sel_ff) begin
            side1_ff <= side;
         end else begin
            side0_ff <= side;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         pt_sel_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         pt_sel_ff <= pt_sel_in;
      end
   end

   always_comb begin
      state_in    = state_ff;
      pt_sel_in   = pt_sel_ff;
      req_tready  = 1'b0;
      rd_en       = 1'b0;
      ctl         = '0;
      res_load    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_tready = 1'b1;
            pt_sel_in  = 1'b0;
            if (req_tvalid) begin
               state_in = (req_tuser == OP_COUNT) ? ST_INDEX : ST_RESULT;
            end
         end
         ST_INDEX: begin
            ctl.index_en = 1'b1;
            state_in     = ST_READ;
         end
         ST_READ: begin
            rd_en    = 1'b1;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            ctl.line_en = 1'b1;
            state_in    = ST_CMP;
         end
         ST_CMP: begin
            if (pt_sel_ff) begin
               state_in = ST_RESULT;
            end else begin
               pt_sel_in = 1'b1;
               state_in  = ST_INDEX;
            end
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_tready) begin
               res_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign cur_x = pt_sel_ff ? ex_ff : sx_ff;
   assign cur_y = pt_sel_ff ? ey_ff : sy_ff;

   assign cp = (op_ff == OP_COUNT) && side0_ff.secondary && side1_ff.primary;
   assign cs = (op_ff == OP_COUNT) && side0_ff.primary && side1_ff.secondary;

   always_ff @(posedge clock) begin
      if (reset) begin
         prim_ff      <= '0;
         sec_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (res_load) begin
            prim_ff      <= prim_ff + COUNT_W'(cp);
            sec_ff       <= sec_ff + COUNT_W'(cs);
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (res_load) begin
         rsp_prim_ff <= prim_ff + COUNT_W'(cp);
         rsp_sec_ff  <= sec_ff + COUNT_W'(cs);
         rsp_cp_ff   <= cp;
         rsp_cs_ff   <= cs;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'b0, rsp_cs_ff, rsp_cp_ff, rsp_sec_ff, rsp_prim_ff};

   plcc_seg_mem u_seg_mem (
      .clock   (clock),
      .wr_en   (accept && (req_tuser == OP_LOAD)
                && (32'(req_tdata[SEG_IDX_W-1:0]) < MAX_SEGMENTS)),
      .wr_addr (ADDR_W'(req_tdata[SEG_IDX_W-1:0])),
      .wr_data (wr_entry),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_entry)
   );

   plcc_point_eval u_point_eval (
      .clock         (clock),
      .ctl           (ctl),
      .x             (cur_x),
      .y             (cur_y),
      .segment_count (seg_count_ff),
      .index_scale   (scale_ff),
      .hyst_margin   (hyst_ff),
      .seg           (rd_entry),
      .rd_addr       (rd_addr),
      .side          (side)
   );

`ifndef NO_ASSERTIONS
   a_count_goes_to_index: assert property (@(posedge clock) disable iff (reset)
      (accept && req_tuser == OP_COUNT) |=> state_ff == ST_INDEX)
      else $error("track step did not start evaluation");
   a_one_flag_at_most: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> !(rsp_cp_ff && rsp_cs_ff))
      else $error("both crossing flags set");
   a_primary_step: assert property (@(posedge clock) disable iff (reset)
      (res_load && cp) |=> prim_ff == $past(prim_ff) + COUNT_W'(1))
      else $error("primary total not advanced");
   a_no_result_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_tready) |-> !res_load)
      else $error("pending result overwritten");
`endif

endmodule
`default_nettype wire

// File: rtl/core/plcc_seg_mem.sv
// Segment coefficient memory: one write port, one registered read port.
`default_nettype none
module plcc_seg_mem
   import plcc_pkg::*;
(
   input  wire logic                 clock,
   input  wire logic                 wr_en,
   input  wire logic [ADDR_W-1:0]    wr_addr,
   input  wire seg_entry_type        wr_data,
   input  wire logic                 rd_en,
   input  wire logic [ADDR_W-1:0]    rd_addr,
   output      seg_entry_type        rd_data
);

   seg_entry_type mem [MAX_SEGMENTS];
   seg_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule
`default_nettype wire

// File: rtl/core/plcc_point_eval.sv
// Point classifier: segment index, line value and hysteresis compare.
`default_nettype none
module plcc_point_eval
   import plcc_pkg::*;
(
   input  wire logic                        clock,
   input  wire eval_ctl_type                ctl,
   input  wire logic signed [COORD_W-1:0]   x,
   input  wire logic signed [COORD_W-1:0]   y,
   input  wire logic [SEG_CNT_W-1:0]        segment_count,
   input  wire logic [SCALE_W-1:0]          index_scale,
   input  wire logic [HYST_W-1:0]           hyst_margin,
   input  wire seg_entry_type               seg,
   output      logic [ADDR_W-1:0]           rd_addr,
   output      side_type                    side
);

   localparam int PROD_W  = COORD_W + SCALE_W + 1;
   localparam int LPROD_W = COORD_W + COEF_W;
   localparam int LINE_W  = 50;
   localparam int YS_W    = HYST_W + 2;
   localparam int Q_W     = 20;

   logic signed [PROD_W-1:0]  prod_ff;
   logic signed [LPROD_W-1:0] lprod_ff;
   logic [COEF_W-1:0]         icpt_ff;
   logic signed [YS_W-1:0]    ylo_ff;
   logic signed [YS_W-1:0]    yhi_ff;

   logic                      pos;
   logic [Q_W-1:0]            q;
   logic [Q_W-1:0]            lim;
   logic [Q_W-1:0]            sel;
   logic signed [LINE_W-1:0]  line;
   logic signed [LINE_W-1:0]  ylo_s;
   logic signed [LINE_W-1:0]  yhi_s;

   always_ff @(posedge clock) begin
      if (ctl.index_en) begin
         prod_ff <= PROD_W'(x * $signed({1'b0, index_scale}));
      end
      if (ctl.line_en) begin
         lprod_ff <= LPROD_W'($signed(seg.slope) * x);
         icpt_ff  <= seg.intercept;
         ylo_ff   <= YS_W'(x - x) + {{(YS_W-COORD_W){y[COORD_W-1]}}, y}
                     - $signed({2'b00, hyst_margin});
         yhi_ff   <= {{(YS_W-COORD_W){y[COORD_W-1]}}, y}
                     + $signed({2'b00, hyst_margin});
      end
   end

   always_comb begin
      pos = !prod_ff[PROD_W-1] && (prod_ff != '0);
      q   = prod_ff[PROD_W-2 -: Q_W];
      if (segment_count == '0) begin
         lim = '0;
      end else if (Q_W'(segment_count) > Q_W'(MAX_SEGMENTS)) begin
         lim = Q_W'(MAX_SEGMENTS - 1);
      end else begin
         lim = Q_W'(segment_count) - Q_W'(1);
      end
      if (!pos) begin
         sel = '0;
      end else if (q > lim) begin
         sel = lim;
      end else begin
         sel = q;
      end
      rd_addr = ADDR_W'(sel);
   end

   always_comb begin
      line  = {{(LINE_W-LPROD_W){lprod_ff[LPROD_W-1]}}, lprod_ff}
              + {{(LINE_W-COEF_W-8){icpt_ff[COEF_W-1]}}, icpt_ff, 8'b0};
      ylo_s = {{(LINE_W-YS_W-16){ylo_ff[YS_W-1]}}, ylo_ff, 16'b0};
      yhi_s = {{(LINE_W-YS_W-16){yhi_ff[YS_W-1]}}, yhi_ff, 16'b0};
      side.secondary = ylo_s > line;
      side.primary   = yhi_s <= line;
   end

`ifndef NO_ASSERTIONS
   a_sides_exclusive: assert property (@(posedge clock)
      ctl.line_en |=> !(side.secondary && side.primary))
      else $error("point classified on both sides");
   a_addr_in_range: assert property (@(posedge clock)
      ctl.index_en |=> 32'(rd_addr) < MAX_SEGMENTS)
      else $error("segment address beyond table");
   a_neg_x_first_segment: assert property (@(posedge clock)
      (ctl.index_en && x[COORD_W-1]) |=> rd_addr == '0)
      else $error("negative x did not map to first segment");
`endif

endmodule
`default_nettype wire
